>>> hw/rtl/ise_pkg.sv
// Shared types and constants for the insertion sort engine.
// No dependencies; used by ise_cell, insertion_sort_engine_top and the testbench.
package ise_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  insert;
    logic  shift;
    data_t value;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/ise_cell.sv
// One cell of the sorting chain: holds one stored value.
// Depends on ise_pkg for data_t and cell_ctrl_t.
module ise_cell (
  input  logic               clk,
  input  ise_pkg::cell_ctrl_t ctrl,
  input  logic               occ,
  input  ise_pkg::data_t     left_data,
  input  logic               left_keep,
  input  ise_pkg::data_t     right_data,
  output ise_pkg::data_t     data,
  output logic               keep
);
  import ise_pkg::*;

  data_t data_next;

  assign keep = occ && (data <= ctrl.value);

  always_comb begin
    data_next = data;
    if (ctrl.shift) begin
      data_next = right_data;
    end else if (ctrl.insert && !keep) begin
      data_next = left_keep ? ctrl.value : left_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

>>> hw/rtl/insertion_sort_engine_top.sv
// Top level of the insertion sort engine: a chain of ise_cell plus fill count
// and emission control. Depends on ise_pkg and ise_cell.
//
//   channel  | direction | payload
//   s_*      | in        | tdata[31:0] value, tlast end_of_set
//   m_*      | out       | tdata[31:0] sorted_value, tlast run_last, tuser[0] overflowed
//
// For each inserted item, all cells compare against the broadcast value
// at once and each keeps, takes the new value, or takes its left neighbor's.
// The item with tlast starts emission: one transfer per stored entry, up to
// DEPTH of them, shifting the chain toward cell 0; input is held off meanwhile.
// m_tready low stalls the chain. rst empties the store and clears overflow.
module insertion_sort_engine_top #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,
  output logic [0:0]  m_tuser    // [0] overflowed
);
  import ise_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             emitting;
  logic             emitting_next;
  logic             overflow;
  logic             overflow_next;

  logic             in_xfer;
  logic             out_xfer;
  logic             full;
  cell_ctrl_t       ctrl;

  data_t            cell_data [DEPTH];
  logic             cell_keep [DEPTH];

  assign s_tready = !emitting;
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign full     = (count == CNT_W'(DEPTH));

  assign ctrl.insert = in_xfer && !full;
  assign ctrl.shift  = out_xfer;
  assign ctrl.value  = data_t'(s_tdata);

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic  occ;
      logic  lkeep;
      data_t ldata;
      data_t rdata;

      assign occ = (CNT_W'(i) < count);

      if (i == 0) begin : g_first
        assign lkeep = 1'b1;
        assign ldata = ctrl.value;
      end else begin : g_mid
        assign lkeep = cell_keep[i-1];
        assign ldata = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign rdata = cell_data[i];
      end else begin : g_inner
        assign rdata = cell_data[i+1];
      end

      ise_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occ        (occ),
        .left_data  (ldata),
        .left_keep  (lkeep),
        .right_data (rdata),
        .data       (cell_data[i]),
        .keep       (cell_keep[i])
      );
    end
  endgenerate

  always_comb begin
    count_next    = count;
    emitting_next = emitting;
    overflow_next = overflow;
    if (ctrl.insert) begin
      count_next = count + CNT_W'(1);
    end
    if (in_xfer && full) begin
      overflow_next = 1'b1;
    end
    if (in_xfer && s_tlast) begin
      emitting_next = 1'b1;
    end
    if (out_xfer) begin
      count_next = count - CNT_W'(1);
      if (m_tlast) begin
        emitting_next = 1'b0;
        overflow_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      emitting <= 1'b0;
      overflow <= 1'b0;
    end else begin
      count    <= count_next;
      emitting <= emitting_next;
      overflow <= overflow_next;
    end
  end

  assign m_tvalid   = emitting;
  assign m_tdata    = cell_data[0];
  assign m_tlast    = (count == CNT_W'(1));
  assign m_tuser[0] = overflow;

`ifndef SYNTHESIS
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    emitting |-> (count != '0))
    else $error("emission with empty store");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (count == '0 && !overflow && !emitting))
    else $error("store not emptied after run");

  if (DEPTH > 1) begin : g_order_chk
    a_head_order: assert property (@(posedge clk) disable iff (rst)
      (emitting && count > CNT_W'(1)) |-> (cell_data[0] <= cell_data[1]))
      else $error("chain head out of order");
  end
`endif

endmodule

>>> verif/tb_insertion_sort_engine_top.sv
// Testbench for insertion_sort_engine_top: streams sets of signed values and checks
// each emitted run against an in-bench sorted store. Depends on ise_pkg and the RTL.
`timescale 1ns / 100ps

module tb_insertion_sort_engine_top;
  import ise_pkg::*;

  localparam int STORE_DEPTH = 32;

  typedef struct {
    data_t value;
    logic  end_of_set;
  } insert_item_t;

  typedef struct {
    data_t sorted_value;
    logic  run_last;
    logic  overflowed;
  } sorted_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] value
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] sorted_value
  logic        m_tlast;
  logic [0:0]  m_tuser;        // [0] overflowed

  insert_item_t   insert_queue[$];
  sorted_result_t pending_sorted[$];
  insert_item_t   next_item;
  sorted_result_t oldest;

  data_t sorted_store[STORE_DEPTH];
  int    fill_count = 0;
  bit    overflow_seen = 1'b0;

  bit s_taken = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold_left = 0;
  int pushed_count = 0;
  int accepted_count = 0;
  int error_count = 0;

  insertion_sort_engine_top #(.DEPTH(STORE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function void sort_in(data_t v, logic eos);
    int pos;
    int k;
    sorted_result_t r;
    if (fill_count >= STORE_DEPTH) begin
      overflow_seen = 1'b1;
    end else begin
      pos = 0;
      while (pos < fill_count && sorted_store[pos] <= v) pos++;
      for (k = fill_count; k > pos; k--) sorted_store[k] = sorted_store[k-1];
      sorted_store[pos] = v;
      fill_count++;
    end
    if (eos) begin
      for (k = 0; k < fill_count; k++) begin
        r.sorted_value = sorted_store[k];
        r.run_last     = (k == fill_count - 1);
        r.overflowed   = overflow_seen;
        pending_sorted = {pending_sorted, r};
      end
      fill_count    = 0;
      overflow_seen = 1'b0;
    end
  endfunction

  // sample both channels, check the output transfer, then predict the input transfer
  always @(posedge clk) begin
    s_taken = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_sorted.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %0d last %b ovf %b",
                   $time, $signed(m_tdata), m_tlast, m_tuser[0]);
          error_count++;
        end else begin
          oldest = pending_sorted.pop_front();
          if (oldest.sorted_value !== data_t'(m_tdata)) begin
            $display("%0t: sorted_value mismatch, expected %0d, actual %0d",
                     $time, oldest.sorted_value, $signed(m_tdata));
            error_count++;
          end
          if (oldest.run_last !== m_tlast) begin
            $display("%0t: run_last mismatch, expected %b, actual %b",
                     $time, oldest.run_last, m_tlast);
            error_count++;
          end
          if (oldest.overflowed !== m_tuser[0]) begin
            $display("%0t: overflowed mismatch, expected %b, actual %b",
                     $time, oldest.overflowed, m_tuser[0]);
            error_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        s_taken = 1'b1;
        accepted_count++;
        sort_in(data_t'(s_tdata), s_tlast);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_taken) begin
      if (insert_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = insert_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_item.value;
        s_tlast  <= next_item.end_of_set;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // hold off for a requested stretch, else stall at random
  always @(negedge clk) begin
    if (recv_hold_left > 0) begin
      recv_hold_left = recv_hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_item(data_t v, logic eos);
    insert_item_t it;
    it.value      = v;
    it.end_of_set = eos;
    insert_queue = {insert_queue, it};
    pushed_count++;
  endtask

  function automatic data_t pick_value();
    case ($urandom_range(9))
      0: return data_t'(32'h8000_0000);
      1: return data_t'(32'h7FFF_FFFF);
      2, 3: return data_t'(int'($urandom_range(15)) - 8);
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic add_random_sets(int budget);
    int sent;
    int len;
    int pick;
    int i;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(8, 1);
      else if (pick < 85) len = $urandom_range(31, 9);
      else if (pick < 93) len = $urandom_range(33, 32);
      else len = $urandom_range(45, 34);
      for (i = 0; i < len; i++) add_item(pick_value(), i == len - 1);
      sent += len;
    end
  endtask

  task automatic add_sized_set(int len);
    int i;
    for (i = 0; i < len; i++) add_item(pick_value(), i == len - 1);
  endtask

  task automatic drain();
    while (accepted_count != pushed_count || pending_sorted.size() != 0) @(posedge clk);
  endtask

  initial begin
    send_idle_pct = 15;
    recv_idle_pct = 84;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes, zero crossing and equal values in one set
    add_item(data_t'(32'h7FFF_FFFF), 1'b0);
    add_item(data_t'(32'h8000_0000), 1'b0);
    add_item(data_t'(0), 1'b0);
    add_item(data_t'(-1), 1'b0);
    add_item(data_t'(1), 1'b0);
    add_item(data_t'(5), 1'b0);
    add_item(data_t'(5), 1'b0);
    add_item(data_t'(5), 1'b1);
    // single-entry runs
    add_item(data_t'(32'h8000_0000), 1'b1);
    add_item(data_t'(32'h7FFF_FFFF), 1'b1);
    // descending then ascending input
    add_item(data_t'(600), 1'b0);
    add_item(data_t'(400), 1'b0);
    add_item(data_t'(200), 1'b0);
    add_item(data_t'(-200), 1'b0);
    add_item(data_t'(-400), 1'b0);
    add_item(data_t'(-600), 1'b1);
    add_item(data_t'(-3), 1'b0);
    add_item(data_t'(-2), 1'b0);
    add_item(data_t'(-2), 1'b0);
    add_item(data_t'(7), 1'b0);
    add_item(data_t'(9), 1'b1);
    add_random_sets(60);
    drain();

    send_idle_pct = 84;
    recv_idle_pct = 15;
    add_random_sets(60);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    recv_hold_left = 300;
    // full store, then a dropped end-of-set item, then more sets queued behind
    add_sized_set(32);
    add_sized_set(33);
    add_sized_set(40);
    add_sized_set(5);
    drain();
    add_random_sets(60);
    drain();

    repeat (2 * STORE_DEPTH + 16) @(posedge clk);
    if (error_count == 0 && pending_sorted.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ise_pkg.sv
hw/rtl/ise_cell.sv
hw/rtl/insertion_sort_engine_top.sv
verif/tb_insertion_sort_engine_top.sv
